// ===== rtl/kcr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_pkg
// Types, tables and GF(2^8) helpers shared by the Kuznyechik counter-mode block.
// ----------------------------------------------------------------------------
package kcr_pkg;

	localparam int ROUND_KEY_COUNT = 10;
	localparam int KS_STEPS        = 32;

	typedef struct packed {
		logic [63:0] block_high;
		logic [63:0] block_low;
	} kcr_in_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
	} kcr_out_t;

	// One queued request: the block to encrypt and the mask to XOR on the result.
	typedef struct packed {
		logic [127:0] blk;
		logic [127:0] mask;
	} kcr_job_t;

	typedef struct packed {
		logic [255:0] key;
		logic         chg;
	} kcr_key_t;

	typedef enum logic [2:0] {
		REG_KEY0  = 3'd0,
		REG_KEY1  = 3'd1,
		REG_KEY2  = 3'd2,
		REG_KEY3  = 3'd3,
		REG_MODE  = 3'd4,
		REG_CNT   = 3'd5
	} kcr_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_KEY_A,
		ST_KEY_B,
		ST_ENC_A,
		ST_ENC_B,
		ST_DONE
	} kcr_state_t;

	localparam logic [7:0] GF_POLY = 8'hC3;
	localparam logic [7:0] GF_TOP  = 8'h80;

	localparam logic [7:0] LIN_COEF [16] = '{
		8'd1, 8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1,
		8'd251, 8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148};

	localparam logic [7:0] SBOX [256] = '{
		8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
		8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
		8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
		8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
		8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
		8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
		8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
		8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
		8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
		8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
		8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
		8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
		8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
		8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
		8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
		8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6};

	function automatic logic [7:0] gf_mul(input logic [7:0] a_in, input logic [7:0] b_in);
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] r;
		logic       top;
		a = a_in;
		b = b_in;
		r = '0;
		for (int n = 0; n < 8; n++) begin
			top = |(a & GF_TOP);
			if (b[0]) begin
				r = r ^ a;
			end
			a = {a[6:0], 1'b0};
			if (top) begin
				a = a ^ GF_POLY;
			end
			b = {1'b0, b[7:1]};
		end
		return r;
	endfunction

	// One R step: byte 0 leaves, the weighted sum enters as byte 15.
	function automatic logic [127:0] r_step(input logic [127:0] x);
		logic [7:0] acc;
		acc = '0;
		for (int i = 0; i < 16; i++) begin
			acc = acc ^ gf_mul(x[8*i +: 8], LIN_COEF[i]);
		end
		return {acc, x[127:8]};
	endfunction

	// Half of the L layer: eight R steps.
	function automatic logic [127:0] l_half(input logic [127:0] x);
		logic [127:0] v;
		v = x;
		for (int s = 0; s < 8; s++) begin
			v = r_step(v);
		end
		return v;
	endfunction

	function automatic logic [127:0] sub_bytes(input logic [127:0] x);
		logic [127:0] y;
		for (int i = 0; i < 16; i++) begin
			y[8*i +: 8] = SBOX[x[8*i +: 8]];
		end
		return y;
	endfunction

	typedef logic [127:0] kcr_cst_arr_t [KS_STEPS];

	// Key schedule constants, worked out at elaboration.
	function automatic kcr_cst_arr_t ks_consts();
		kcr_cst_arr_t t;
		for (int c = 0; c < KS_STEPS; c++) begin
			t[c] = 128'(c + 1);
			t[c] = l_half(l_half(t[c]));
		end
		return t;
	endfunction

	localparam kcr_cst_arr_t KS_CONST = ks_consts();

endpackage
`default_nettype wire

// ===== rtl/kuznyechik_block_encrypt_ctr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kuznyechik_block_encrypt_ctr
// Kuznyechik block encryption with direct and 64-bit counter modes.
// ----------------------------------------------------------------------------
// One block at a time goes through a single round unit that does half a round
// (key XOR, S-box and eight R steps, or the remaining eight R steps) per
// cycle; the core takes the next block from the input queue only once the
// result of the last one has been registered. After reset or after any key
// word is written, the next request first runs the 32-step key schedule on
// the same unit. A two-entry input queue and a result register let both
// sides stall on their own. Configuration writes are always accepted and
// must be made while idle.
module kuznyechik_block_encrypt_ctr (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire kcr_pkg::kcr_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output kcr_pkg::kcr_out_t      out_data,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [63:0]       cfg_data
);
	import kcr_pkg::*;

	logic [63:0] key_q [4];
	logic        mode_q;
	logic        cnt_load;
	logic        key_wr;
	kcr_key_t    key;
	logic        job_valid;
	logic        job_ready;
	kcr_job_t    job;

	assign cfg_ready = 1'b1;
	assign key_wr    = cfg_valid && (cfg_index inside {REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3});
	assign cnt_load  = cfg_valid && (cfg_index == REG_CNT);
	assign key.key   = {key_q[3], key_q[2], key_q[1], key_q[0]};
	assign key.chg   = key_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q[0] <= '0;
			key_q[1] <= '0;
			key_q[2] <= '0;
			key_q[3] <= '0;
			mode_q   <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_KEY0: key_q[0] <= cfg_data;
				REG_KEY1: key_q[1] <= cfg_data;
				REG_KEY2: key_q[2] <= cfg_data;
				REG_KEY3: key_q[3] <= cfg_data;
				REG_MODE: mode_q   <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	kcr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.mode      (mode_q),
		.cnt_load  (cnt_load),
		.cnt_value (cfg_data),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job)
	);

	kcr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

// ===== rtl/kcr_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_front
// Takes input requests, forms the block and mask for the chosen mode, and
// queues them for the cipher core in a two-entry queue.
// ----------------------------------------------------------------------------
module kcr_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire kcr_pkg::kcr_in_t in_data,
	input  wire logic             mode,
	input  wire logic             cnt_load,
	input  wire logic [63:0]      cnt_value,
	output logic                  job_valid,
	input  wire logic             job_ready,
	output kcr_pkg::kcr_job_t     job
);
	import kcr_pkg::*;

	kcr_job_t    q_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  cnt_q;
	logic [63:0] ctr_q;
	kcr_job_t    entry;
	logic        push;
	logic        pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign job_valid = (cnt_q != 2'd0);
	assign job       = q_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = job_valid && job_ready;

	always_comb begin
		if (mode) begin
			entry.blk  = {64'd0, ctr_q};
			entry.mask = {in_data.block_high, in_data.block_low};
		end else begin
			entry.blk  = {in_data.block_high, in_data.block_low};
			entry.mask = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
			ctr_q    <= '0;
		end else begin
			if (cnt_load) begin
				ctr_q <= cnt_value;
			end else if (push && mode) begin
				ctr_q <= ctr_q + 64'd1;
			end
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wr_ptr_q] <= entry;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kcr_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_core
// Iterative Kuznyechik engine: derives round keys after reset or a key change,
// encrypts one queued block at half a round per cycle and holds the result.
// ----------------------------------------------------------------------------
module kcr_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire kcr_pkg::kcr_key_t key,
	input  wire logic              job_valid,
	output logic                   job_ready,
	input  wire kcr_pkg::kcr_job_t job,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output kcr_pkg::kcr_out_t      out_data
);
	import kcr_pkg::*;

	kcr_state_t   state_q;
	kcr_state_t   state_d;
	logic         keys_ok_q;
	logic [127:0] rk_q [ROUND_KEY_COUNT];
	logic [127:0] kl_q;
	logic [127:0] kr_q;
	logic [127:0] st_q;
	logic [127:0] tmp_q;
	logic [127:0] mask_q;
	logic [4:0]   step_q;
	logic [3:0]   rnd_q;
	logic         res_vld_q;
	kcr_out_t     res_q;
	logic [127:0] ks_t;
	logic [127:0] enc_n;
	logic [3:0]   rk_idx;
	logic         res_load;

	assign ks_t     = l_half(tmp_q) ^ kl_q;
	assign enc_n    = l_half(tmp_q);
	assign rk_idx   = {step_q[4:3], 1'b0} + 4'd2;
	assign res_load = (state_q == ST_DONE) && (!res_vld_q || out_ready);
	assign out_valid = res_vld_q;
	assign out_data  = res_q;

	always_comb begin
		state_d   = state_q;
		job_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					state_d = keys_ok_q ? ST_ENC_A : ST_KEY_A;
				end
			end
			ST_KEY_A: state_d = ST_KEY_B;
			ST_KEY_B: begin
				state_d = (step_q == 5'(KS_STEPS - 1)) ? ST_ENC_A : ST_KEY_A;
			end
			ST_ENC_A: state_d = ST_ENC_B;
			ST_ENC_B: begin
				state_d = (rnd_q == 4'(ROUND_KEY_COUNT - 2)) ? ST_DONE : ST_ENC_A;
			end
			ST_DONE: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_ok_q <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (key.chg) begin
				keys_ok_q <= 1'b0;
			end else if (state_q == ST_KEY_B && step_q == 5'(KS_STEPS - 1)) begin
				keys_ok_q <= 1'b1;
			end
			if (res_load) begin
				res_vld_q <= 1'b1;
			end else if (out_ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				st_q   <= job.blk;
				mask_q <= job.mask;
				rnd_q  <= '0;
				step_q <= '0;
				kl_q   <= key.key[127:0];
				kr_q   <= key.key[255:128];
				if (job_valid && !keys_ok_q) begin
					rk_q[0] <= key.key[255:128];
					rk_q[1] <= key.key[127:0];
				end
			end
			ST_KEY_A: tmp_q <= l_half(sub_bytes(kr_q ^ KS_CONST[step_q]));
			ST_KEY_B: begin
				kl_q   <= kr_q;
				kr_q   <= ks_t;
				step_q <= step_q + 5'd1;
				// Every eighth Feistel step yields the next pair of round keys.
				if (step_q[2:0] == 3'd7) begin
					rk_q[rk_idx]        <= ks_t;
					rk_q[rk_idx + 4'd1] <= kr_q;
				end
			end
			ST_ENC_A: tmp_q <= l_half(sub_bytes(st_q ^ rk_q[rnd_q]));
			ST_ENC_B: begin
				rnd_q <= rnd_q + 4'd1;
				if (rnd_q == 4'(ROUND_KEY_COUNT - 2)) begin
					st_q <= enc_n ^ rk_q[ROUND_KEY_COUNT - 1] ^ mask_q;
				end else begin
					st_q <= enc_n;
				end
			end
			default: begin
			end
		endcase
		if (res_load) begin
			res_q <= st_q;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/kcr_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// kcr_checker
// Port-level checks on the Kuznyechik block, bound to the top level.
// ----------------------------------------------------------------------------
module kcr_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire kcr_pkg::kcr_out_t out_data,
	input wire logic              cfg_valid,
	input wire logic              cfg_ready
);

	// A waiting result must hold still until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

	// Straight after reset the input queue can take a request and no result is held.
	a_reset_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> in_ready && !out_valid)
		else $error("block not idle after reset");

	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_data))
		else $error("result carries unknown bits");

endmodule

bind kuznyechik_block_encrypt_ctr kcr_checker u_chk (.*);
`default_nettype wire

// ===== tb/kuznyechik_block_encrypt_ctr_checker.sv =====
// ----------------------------------------------------------------------------
// kuznyechik_block_encrypt_ctr_checker
// Watches the configuration, input and result channels of the cipher block,
// keeps its own cipher state, predicts every result and compares it in order.
// ----------------------------------------------------------------------------
module kuznyechik_block_encrypt_ctr_checker
	import kcr_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire kcr_in_t     in_data,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire kcr_out_t    out_data,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	output int               fail_count,
	output int               pending
);

	localparam logic [7:0] GF_REDUCE = 8'hC3;

	localparam logic [7:0] MIX_WEIGHT [16] = '{
		8'd1, 8'd148, 8'd32, 8'd133, 8'd16, 8'd194, 8'd192, 8'd1,
		8'd251, 8'd1, 8'd192, 8'd194, 8'd16, 8'd133, 8'd32, 8'd148};

	localparam logic [7:0] PI_TABLE [256] = '{
		8'hFC,8'hEE,8'hDD,8'h11,8'hCF,8'h6E,8'h31,8'h16,8'hFB,8'hC4,8'hFA,8'hDA,8'h23,8'hC5,8'h04,8'h4D,
		8'hE9,8'h77,8'hF0,8'hDB,8'h93,8'h2E,8'h99,8'hBA,8'h17,8'h36,8'hF1,8'hBB,8'h14,8'hCD,8'h5F,8'hC1,
		8'hF9,8'h18,8'h65,8'h5A,8'hE2,8'h5C,8'hEF,8'h21,8'h81,8'h1C,8'h3C,8'h42,8'h8B,8'h01,8'h8E,8'h4F,
		8'h05,8'h84,8'h02,8'hAE,8'hE3,8'h6A,8'h8F,8'hA0,8'h06,8'h0B,8'hED,8'h98,8'h7F,8'hD4,8'hD3,8'h1F,
		8'hEB,8'h34,8'h2C,8'h51,8'hEA,8'hC8,8'h48,8'hAB,8'hF2,8'h2A,8'h68,8'hA2,8'hFD,8'h3A,8'hCE,8'hCC,
		8'hB5,8'h70,8'h0E,8'h56,8'h08,8'h0C,8'h76,8'h12,8'hBF,8'h72,8'h13,8'h47,8'h9C,8'hB7,8'h5D,8'h87,
		8'h15,8'hA1,8'h96,8'h29,8'h10,8'h7B,8'h9A,8'hC7,8'hF3,8'h91,8'h78,8'h6F,8'h9D,8'h9E,8'hB2,8'hB1,
		8'h32,8'h75,8'h19,8'h3D,8'hFF,8'h35,8'h8A,8'h7E,8'h6D,8'h54,8'hC6,8'h80,8'hC3,8'hBD,8'h0D,8'h57,
		8'hDF,8'hF5,8'h24,8'hA9,8'h3E,8'hA8,8'h43,8'hC9,8'hD7,8'h79,8'hD6,8'hF6,8'h7C,8'h22,8'hB9,8'h03,
		8'hE0,8'h0F,8'hEC,8'hDE,8'h7A,8'h94,8'hB0,8'hBC,8'hDC,8'hE8,8'h28,8'h50,8'h4E,8'h33,8'h0A,8'h4A,
		8'hA7,8'h97,8'h60,8'h73,8'h1E,8'h00,8'h62,8'h44,8'h1A,8'hB8,8'h38,8'h82,8'h64,8'h9F,8'h26,8'h41,
		8'hAD,8'h45,8'h46,8'h92,8'h27,8'h5E,8'h55,8'h2F,8'h8C,8'hA3,8'hA5,8'h7D,8'h69,8'hD5,8'h95,8'h3B,
		8'h07,8'h58,8'hB3,8'h40,8'h86,8'hAC,8'h1D,8'hF7,8'h30,8'h37,8'h6B,8'hE4,8'h88,8'hD9,8'hE7,8'h89,
		8'hE1,8'h1B,8'h83,8'h49,8'h4C,8'h3F,8'hF8,8'hFE,8'h8D,8'h53,8'hAA,8'h90,8'hCA,8'hD8,8'h85,8'h61,
		8'h20,8'h71,8'h67,8'hA4,8'h2D,8'h2B,8'h09,8'h5B,8'hCB,8'h9B,8'h25,8'hD0,8'hBE,8'hE5,8'h6C,8'h52,
		8'h59,8'hA6,8'h74,8'hD2,8'hE6,8'hF4,8'hB4,8'hC0,8'hD1,8'h66,8'hAF,8'hC2,8'h39,8'h4B,8'h63,8'hB6};

	logic [63:0]  key_word [4];
	logic         ctr_mode;
	logic [63:0]  block_ctr;
	logic [127:0] round_key [ROUND_KEY_COUNT];
	bit           schedule_valid;
	kcr_out_t     expected_blocks [$];

	function automatic logic [7:0] field_mul(input logic [7:0] x, input logic [7:0] y);
		logic [7:0] prod;
		prod = '0;
		for (int n = 0; n < 8; n++) begin
			if (y[n]) begin
				prod ^= x;
			end
			x = x[7] ? ({x[6:0], 1'b0} ^ GF_REDUCE) : {x[6:0], 1'b0};
		end
		return prod;
	endfunction

	// Byte i of a block sits at bits 8i+7..8i; each step shifts byte 0 out.
	function automatic logic [127:0] mix_layer(input logic [127:0] v);
		logic [7:0] acc;
		for (int s = 0; s < 16; s++) begin
			acc = '0;
			for (int i = 0; i < 16; i++) begin
				acc ^= field_mul(v[8*i +: 8], MIX_WEIGHT[i]);
			end
			v = {acc, v[127:8]};
		end
		return v;
	endfunction

	function automatic logic [127:0] substitute(input logic [127:0] v);
		for (int i = 0; i < 16; i++) begin
			v[8*i +: 8] = PI_TABLE[v[8*i +: 8]];
		end
		return v;
	endfunction

	task automatic expand_key();
		logic [127:0] left;
		logic [127:0] right;
		logic [127:0] tmp;
		int k;
		left = {key_word[1], key_word[0]};
		right = {key_word[3], key_word[2]};
		round_key[0] = right;
		round_key[1] = left;
		k = 2;
		for (int c = 0; c < 32; c++) begin
			tmp = mix_layer(substitute(right ^ mix_layer(128'(c + 1)))) ^ left;
			left = right;
			right = tmp;
			if ((c % 8) == 7 && k + 1 < ROUND_KEY_COUNT) begin
				round_key[k] = right;
				round_key[k + 1] = left;
				k += 2;
			end
		end
		schedule_valid = 1'b1;
	endtask

	function automatic logic [127:0] cipher_block(input logic [127:0] v);
		for (int r = 0; r < ROUND_KEY_COUNT - 1; r++) begin
			v = mix_layer(substitute(v ^ round_key[r]));
		end
		return v ^ round_key[ROUND_KEY_COUNT - 1];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [127:0] res;
		kcr_out_t got;
		kcr_out_t want;
		if (!arst_n) begin
			foreach (key_word[i]) key_word[i] = '0;
			foreach (round_key[i]) round_key[i] = '0;
			ctr_mode = 1'b0;
			block_ctr = '0;
			schedule_valid = 1'b0;
			expected_blocks.delete();
			fail_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
						key_word[cfg_index[1:0]] = cfg_data;
						schedule_valid = 1'b0;
					end
					REG_MODE: ctr_mode = cfg_data[0];
					REG_CNT: block_ctr = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (!schedule_valid) begin
					expand_key();
				end
				if (ctr_mode) begin
					res = cipher_block({64'd0, block_ctr}) ^ in_data;
					block_ctr = block_ctr + 64'd1;
				end else begin
					res = cipher_block(in_data);
				end
				expected_blocks.push_back(kcr_out_t'(res));
			end
			if (out_valid && out_ready) begin
				got = out_data;
				if (expected_blocks.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected result %h_%h", got.result_high, got.result_low);
					end
				end else begin
					want = expected_blocks.pop_front();
					if (got.result_low !== want.result_low
							|| got.result_high !== want.result_high) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result mismatch: expected %h_%h, got %h_%h",
								want.result_high, want.result_low,
								got.result_high, got.result_low);
						end
					end
				end
			end
		end
		pending = expected_blocks.size();
	end

endmodule

// ===== tb/kuznyechik_block_encrypt_ctr_test.sv =====
// ----------------------------------------------------------------------------
// kuznyechik_block_encrypt_ctr_test
// Drives keys, modes, counters and data blocks into the cipher block, in part
// under random stalls on both sides; the checker beside it predicts the results.
// ----------------------------------------------------------------------------
module kuznyechik_block_encrypt_ctr_test;
	import kcr_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 100;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	kcr_in_t     in_data;
	logic        out_valid;
	logic        out_ready;
	kcr_out_t    out_data;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	int          fail_count;
	int          pending;

	int tx_idle_pct;
	int rx_idle_pct;
	int hold_req;
	int hold_done;
	int hold_left;
	int quiet_cycles;

	kuznyechik_block_encrypt_ctr dut (.*);

	kuznyechik_block_encrypt_ctr_checker scoreboard (.*);

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver: random stalls, or one long hold-off when asked.
	initial begin
		out_ready = 1'b0;
		hold_done = 0;
		hold_left = 0;
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_done != hold_req) begin
			out_ready <= 1'b0;
			hold_left <= 300;
			hold_done <= hold_done + 1;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	task automatic send_block(input logic [63:0] lo, input logic [63:0] hi);
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		in_data <= '{block_high: hi, block_low: lo};
		do @(posedge clk); while (!in_ready);
	endtask

	// Leaves the block idle: input lowered, every result back, a margin after.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Valid stays high across back-to-back writes; the caller lowers it.
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic load_key(input logic [63:0] k0, k1, k2, k3);
		write_reg(REG_KEY0, k0);
		write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2);
		write_reg(REG_KEY3, k3);
	endtask

	task automatic random_setting();
		int pick;
		pick = $urandom_range(3);
		if (pick == 0) begin
			write_reg(REG_KEY0 + 3'($urandom_range(3)), rand_word());
		end else if (pick != 3) begin
			load_key(rand_word(), rand_word(), rand_word(), rand_word());
		end
		write_reg(REG_MODE, rand_word());
		if ($urandom_range(1) == 1) begin
			write_reg(REG_CNT, 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(20)));
		end else begin
			write_reg(REG_CNT, rand_word());
		end
		cfg_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_KEY0;
		cfg_data = '0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req = 0;
		quiet_cycles = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Straight after reset the all-zero key is in use.
		send_block('0, '0);
		send_block('1, '1);
		send_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
		drain();

		load_key('1, '1, '1, '1);
		write_reg(REG_UNUSED, '1);
		cfg_valid <= 1'b0;
		send_block('0, '1);
		send_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
		drain();

		// Counter mode from the top of the range, so the counter wraps.
		load_key(rand_word(), rand_word(), rand_word(), rand_word());
		write_reg(REG_MODE, 64'd3);
		write_reg(REG_CNT, 64'hFFFF_FFFF_FFFF_FFFE);
		cfg_valid <= 1'b0;
		for (int i = 0; i < 4; i++) send_block('0, '0);
		send_block('1, '1);
		drain();

		// Only bit 0 of the mode is kept, so this is direct mode again.
		write_reg(REG_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
		write_reg(REG_CNT, '0);
		cfg_valid <= 1'b0;
		send_block('1, '0);
		send_block(rand_word(), rand_word());
		drain();
		write_reg(REG_MODE, 64'd1);
		cfg_valid <= 1'b0;
		send_block('0, '0);
		send_block(rand_word(), rand_word());
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			tx_idle_pct = (phase == 0) ? 29 : (phase == 1) ? 64 : 0;
			rx_idle_pct = (phase == 0) ? 64 : (phase == 1) ? 29 : 0;
			for (int part = 0; part < 3; part++) begin
				random_setting();
				if (phase == 0 && part == 1) begin
					hold_req = hold_req + 1;
				end
				for (int n = 0; n < 50; n++) begin
					send_block(rand_word(), rand_word());
				end
				drain();
			end
		end

		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
